### sv/jhsv_pkg.sv
// Shared types, constants, microcode program and helper functions of the stick color controller.
package jhsv_pkg;

	localparam int MUL_AW = 21;
	localparam int MUL_BW = 21;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int STEP_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [14:0] HUE_FULL = 15'd23040;
	localparam logic [11:0] SECTOR_SPAN = 12'd3840;
	localparam logic [19:0] RECIP15 = 20'd559241;
	localparam logic [8:0] HUE_SPEED_MAX = 9'd360;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_SPEED,
		REG_VALUE_SPEED,
		REG_DEAD_ZONE,
		REG_SMOOTHING,
		REG_VALUE_FLOOR,
		REG_SATURATION,
		REG_OUTER_SCALE
	} cfg_reg_t;

	typedef struct packed {
		logic [8:0]  hue_speed;
		logic [15:0] value_speed;
		logic [14:0] dead_zone;
		logic [15:0] smoothing;
		logic [15:0] value_floor;
		logic [15:0] saturation;
		logic [15:0] outer_scale;
	} cfg_t;

	typedef enum logic [3:0] {
		A_NONE, A_X, A_NY, A_HDIFF, A_VDIFF, A_HRATE, A_BRATE, A_BRI,
		A_C, A_Z, A_QR, A_QG, A_QB, A_IR, A_IG, A_IB
	} opa_t;

	typedef enum logic [3:0] {
		B_NONE, B_HS, B_VSPD, B_SMOOTH, B_FT, B_SAT, B_T, B_RECIP, B_MAXC, B_OSC
	} opb_t;

	typedef enum logic [3:0] {
		W_NONE, W_HTGT, W_VTGT, W_HRATE, W_BRATE, W_HUE, W_BRI, W_C,
		W_Z, W_XC, W_IR, W_IG, W_IB, W_OR, W_OG, W_OB
	} wb_t;

	typedef enum logic [1:0] {
		SQ_NEXT, SQ_WAIT_IN, SQ_FINISH
	} seq_t;

	typedef struct packed {
		opa_t op_a;
		opb_t op_b;
		wb_t  wb;
		seq_t seq;
	} ucode_t;

	typedef struct packed {
		ucode_t uc;
		logic   in_ready;
		logic   load_in;
		logic   load_out;
	} seq_ctrl_t;

	function automatic ucode_t uw(opa_t a, opb_t b, wb_t w, seq_t q);
		ucode_t u;
		u.op_a = a;
		u.op_b = b;
		u.wb = w;
		u.seq = q;
		return u;
	endfunction

	// Each step issues at most one product and may write back the product of the step before.
	function automatic ucode_t ucode_rom(logic [STEP_W-1:0] s);
		ucode_t u;
		case (s)
			5'd0:  u = uw(A_NONE,  B_NONE,   W_NONE,  SQ_WAIT_IN);
			5'd1:  u = uw(A_X,     B_HS,     W_NONE,  SQ_NEXT);
			5'd2:  u = uw(A_NY,    B_VSPD,   W_HTGT,  SQ_NEXT);
			5'd3:  u = uw(A_HDIFF, B_SMOOTH, W_VTGT,  SQ_NEXT);
			5'd4:  u = uw(A_VDIFF, B_SMOOTH, W_HRATE, SQ_NEXT);
			5'd5:  u = uw(A_HRATE, B_FT,     W_BRATE, SQ_NEXT);
			5'd6:  u = uw(A_BRATE, B_FT,     W_HUE,   SQ_NEXT);
			5'd7:  u = uw(A_NONE,  B_NONE,   W_BRI,   SQ_NEXT);
			5'd8:  u = uw(A_BRI,   B_SAT,    W_NONE,  SQ_NEXT);
			5'd9:  u = uw(A_NONE,  B_NONE,   W_C,     SQ_NEXT);
			5'd10: u = uw(A_C,     B_T,      W_NONE,  SQ_NEXT);
			5'd11: u = uw(A_NONE,  B_NONE,   W_Z,     SQ_NEXT);
			5'd12: u = uw(A_Z,     B_RECIP,  W_NONE,  SQ_NEXT);
			5'd13: u = uw(A_NONE,  B_NONE,   W_XC,    SQ_NEXT);
			5'd14: u = uw(A_QR,    B_MAXC,   W_NONE,  SQ_NEXT);
			5'd15: u = uw(A_QG,    B_MAXC,   W_IR,    SQ_NEXT);
			5'd16: u = uw(A_QB,    B_MAXC,   W_IG,    SQ_NEXT);
			5'd17: u = uw(A_IR,    B_OSC,    W_IB,    SQ_NEXT);
			5'd18: u = uw(A_IG,    B_OSC,    W_OR,    SQ_NEXT);
			5'd19: u = uw(A_IB,    B_OSC,    W_OG,    SQ_NEXT);
			5'd20: u = uw(A_NONE,  B_NONE,   W_OB,    SQ_NEXT);
			5'd21: u = uw(A_NONE,  B_NONE,   W_NONE,  SQ_FINISH);
			default: u = uw(A_NONE, B_NONE,  W_NONE,  SQ_FINISH);
		endcase
		return u;
	endfunction

	function automatic logic [2:0] hue_sector(logic [14:0] h);
		logic [2:0] s;
		if (h < 15'd3840) begin
			s = 3'd0;
		end else if (h < 15'd7680) begin
			s = 3'd1;
		end else if (h < 15'd11520) begin
			s = 3'd2;
		end else if (h < 15'd15360) begin
			s = 3'd3;
		end else if (h < 15'd19200) begin
			s = 3'd4;
		end else begin
			s = 3'd5;
		end
		return s;
	endfunction

	function automatic logic [14:0] sector_base(logic [2:0] s);
		logic [14:0] b;
		case (s)
			3'd0: b = 15'd0;
			3'd1: b = 15'd3840;
			3'd2: b = 15'd7680;
			3'd3: b = 15'd11520;
			3'd4: b = 15'd15360;
			default: b = 15'd19200;
		endcase
		return b;
	endfunction

	// Floor division by 65535 of a value below 2^32 - 2^16, so that the quotient fits in 16 bits.
	function automatic logic [15:0] div65535(logic [31:0] y);
		logic [16:0] qe;
		logic [16:0] r1;
		logic [16:0] q;
		qe = {1'b0, y[31:16]};
		r1 = {1'b0, y[15:0]} + qe;
		if (r1 >= 17'd131070) begin
			q = qe + 17'd2;
		end else if (r1 >= 17'd65535) begin
			q = qe + 17'd1;
		end else begin
			q = qe;
		end
		return q[15:0];
	endfunction

endpackage

### sv/jhsv_useq.sv
// Microcode sequencer: step counter, program table and wait conditions.
module jhsv_useq
	import jhsv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	output seq_ctrl_t ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	ucode_t uc;

	assign uc = ucode_rom(step_q);

	always_comb begin
		ctrl.uc = uc;
		ctrl.in_ready = (uc.seq == SQ_WAIT_IN);
		ctrl.load_in = (uc.seq == SQ_WAIT_IN) && in_valid;
		ctrl.load_out = (uc.seq == SQ_FINISH) && out_free;
	end

	always_comb begin
		case (uc.seq)
			SQ_NEXT: begin
				step_next = step_q + STEP_W'(1);
			end
			SQ_WAIT_IN: begin
				step_next = in_valid ? step_q + STEP_W'(1) : step_q;
			end
			SQ_FINISH: begin
				step_next = out_free ? '0 : step_q;
			end
			default: begin
				step_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

### sv/jhsv_dpath.sv
// Datapath: kept state, operand selection, shared multiplier and write-back logic.
module jhsv_dpath
	import jhsv_pkg::*;
#(
	parameter int COLOR_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  seq_ctrl_t               ctrl,
	input  cfg_t                    cfg,
	input  logic signed [15:0]      stick_x,
	input  logic signed [15:0]      stick_y,
	input  logic [15:0]             frame_time,
	output logic [COLOR_BITS-1:0]   res_ir,
	output logic [COLOR_BITS-1:0]   res_ig,
	output logic [COLOR_BITS-1:0]   res_ib,
	output logic [COLOR_BITS-1:0]   res_or,
	output logic [COLOR_BITS-1:0]   res_og,
	output logic [COLOR_BITS-1:0]   res_ob
);

	localparam logic [MUL_BW-1:0] MaxC = MUL_BW'((1 << COLOR_BITS) - 1);

	logic signed [16:0] x_q, ny_q;
	logic [15:0] ft_q;
	logic [14:0] hue_q;
	logic [15:0] bri_q;
	logic signed [15:0] hrate_q, htgt_q;
	logic signed [17:0] brate_q, vtgt_q;
	logic [15:0] c_q, m_q, xc_q;
	logic [19:0] z_q;
	logic [COLOR_BITS-1:0] ir_q, ig_q, ib_q, or_q, og_q, ob_q;
	logic signed [MUL_PW-1:0] p_q;

	logic signed [16:0] sx, sy, ax, ay, x_dz, y_dz;
	logic signed [16:0] hdiff;
	logic signed [18:0] vdiff;
	logic [8:0] hs_lim;
	logic [2:0] sector;
	logic [14:0] f_hue;
	logic [11:0] t_val;
	logic [15:0] ch_r, ch_g, ch_b;
	logic [16:0] qr, qg, qb;
	logic signed [MUL_AW-1:0] opa;
	logic signed [MUL_BW-1:0] opb;
	logic signed [MUL_PW-1:0] prod;
	logic signed [MUL_PW-1:0] rs9, rs15, rs16;
	logic signed [17:0] hsum;
	logic [14:0] hue_new;
	logic signed [19:0] bsum;
	logic [15:0] bri_new;

	always_comb begin
		sx = 17'(stick_x);
		sy = 17'(stick_y);
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		x_dz = ($unsigned(ax) < 17'(cfg.dead_zone)) ? 17'sd0 : sx;
		y_dz = ($unsigned(ay) < 17'(cfg.dead_zone)) ? 17'sd0 : sy;
	end

	always_comb begin
		hdiff = 17'(htgt_q) - 17'(hrate_q);
		vdiff = 19'(vtgt_q) - 19'(brate_q);
		hs_lim = (cfg.hue_speed > HUE_SPEED_MAX) ? HUE_SPEED_MAX : cfg.hue_speed;
		sector = hue_sector(hue_q);
		f_hue = hue_q - sector_base(sector);
		t_val = sector[0] ? SECTOR_SPAN - f_hue[11:0] : f_hue[11:0];
	end

	always_comb begin
		case (sector)
			3'd0: begin ch_r = c_q;   ch_g = xc_q;  ch_b = 16'd0; end
			3'd1: begin ch_r = xc_q;  ch_g = c_q;   ch_b = 16'd0; end
			3'd2: begin ch_r = 16'd0; ch_g = c_q;   ch_b = xc_q;  end
			3'd3: begin ch_r = 16'd0; ch_g = xc_q;  ch_b = c_q;   end
			3'd4: begin ch_r = xc_q;  ch_g = 16'd0; ch_b = c_q;   end
			default: begin ch_r = c_q; ch_g = 16'd0; ch_b = xc_q; end
		endcase
		qr = {1'b0, ch_r} + {1'b0, m_q};
		qg = {1'b0, ch_g} + {1'b0, m_q};
		qb = {1'b0, ch_b} + {1'b0, m_q};
	end

	always_comb begin
		case (ctrl.uc.op_a)
			A_X:     opa = MUL_AW'(x_q);
			A_NY:    opa = MUL_AW'(ny_q);
			A_HDIFF: opa = MUL_AW'(hdiff);
			A_VDIFF: opa = MUL_AW'(vdiff);
			A_HRATE: opa = MUL_AW'(hrate_q);
			A_BRATE: opa = MUL_AW'(brate_q);
			A_BRI:   opa = MUL_AW'(bri_q);
			A_C:     opa = MUL_AW'(c_q);
			A_Z:     opa = MUL_AW'(z_q);
			A_QR:    opa = MUL_AW'(qr[15:0]);
			A_QG:    opa = MUL_AW'(qg[15:0]);
			A_QB:    opa = MUL_AW'(qb[15:0]);
			A_IR:    opa = MUL_AW'(ir_q);
			A_IG:    opa = MUL_AW'(ig_q);
			A_IB:    opa = MUL_AW'(ib_q);
			default: opa = '0;
		endcase
	end

	always_comb begin
		case (ctrl.uc.op_b)
			B_HS:     opb = MUL_BW'(hs_lim);
			B_VSPD:   opb = MUL_BW'(cfg.value_speed);
			B_SMOOTH: opb = MUL_BW'(cfg.smoothing);
			B_FT:     opb = MUL_BW'(ft_q);
			B_SAT:    opb = MUL_BW'(cfg.saturation);
			B_T:      opb = MUL_BW'(t_val);
			B_RECIP:  opb = MUL_BW'(RECIP15);
			B_MAXC:   opb = MaxC;
			B_OSC:    opb = MUL_BW'(cfg.outer_scale);
			default:  opb = '0;
		endcase
	end

	assign prod = opa * opb;

	always_comb begin
		rs9 = (p_q + $signed(MUL_PW'(256))) >>> 9;
		rs15 = (p_q + $signed(MUL_PW'(16384))) >>> 15;
		rs16 = (p_q + $signed(MUL_PW'(32768))) >>> 16;
		hsum = $signed({3'b000, hue_q}) + $signed(rs16[17:0]);
		if (hsum >= $signed({3'b000, HUE_FULL})) begin
			hue_new = 15'(hsum - $signed({3'b000, HUE_FULL}));
		end else if (hsum < 0) begin
			hue_new = 15'(hsum + $signed({3'b000, HUE_FULL}));
		end else begin
			hue_new = hsum[14:0];
		end
		bsum = $signed({4'b0000, bri_q}) + $signed(rs16[19:0]);
		if (bsum < $signed({4'b0000, cfg.value_floor})) begin
			bri_new = cfg.value_floor;
		end else if (bsum > $signed(20'd65535)) begin
			bri_new = 16'hFFFF;
		end else begin
			bri_new = bsum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q <= 15'd7680;
			bri_q <= 16'd58982;
			hrate_q <= '0;
			brate_q <= '0;
		end else begin
			case (ctrl.uc.wb)
				W_HRATE: hrate_q <= hrate_q + rs16[15:0];
				W_BRATE: brate_q <= brate_q + rs16[17:0];
				W_HUE:   hue_q <= hue_new;
				W_BRI:   bri_q <= bri_new;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			x_q <= x_dz;
			ny_q <= -y_dz;
			ft_q <= frame_time;
		end
		if (ctrl.uc.op_a != A_NONE) begin
			p_q <= prod;
		end
		case (ctrl.uc.wb)
			W_HTGT: htgt_q <= rs9[15:0];
			W_VTGT: vtgt_q <= rs15[17:0];
			W_C: begin
				c_q <= rs16[15:0];
				m_q <= bri_q - rs16[15:0];
			end
			W_Z:  z_q <= 20'((p_q + $signed(MUL_PW'(1920))) >>> 8);
			W_XC: xc_q <= 16'(p_q >>> 23);
			W_IR: ir_q <= COLOR_BITS'(div65535(32'(p_q + $signed(MUL_PW'(32767)))));
			W_IG: ig_q <= COLOR_BITS'(div65535(32'(p_q + $signed(MUL_PW'(32767)))));
			W_IB: ib_q <= COLOR_BITS'(div65535(32'(p_q + $signed(MUL_PW'(32767)))));
			W_OR: or_q <= COLOR_BITS'(rs16);
			W_OG: og_q <= COLOR_BITS'(rs16);
			W_OB: ob_q <= COLOR_BITS'(rs16);
			default: begin
			end
		endcase
	end

	assign res_ir = ir_q;
	assign res_ig = ig_q;
	assign res_ib = ib_q;
	assign res_or = or_q;
	assign res_og = og_q;
	assign res_ob = ob_q;

endmodule

### sv/joystick_hsv_color_controller_core.sv
// Top level of the stick color controller: registers, output register and sequencer hookup.
//
//   Channel  Handshake              Beat contents
//   in       in_valid / in_ready    stick_x, stick_y, frame_time
//   out      out_valid / out_ready  inner_red/green/blue, outer_red/green/blue
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each input beat runs the 22-step microcode program, which issues at most one product
// per step to the single shared 21 x 21 multiplier.
// The next input beat can first be taken in the cycle after the result enters the output register.
// A result waiting in the output register holds the sequencer at its last step.
// Reset restores the default registers, the hue and brightness state and zero rates.
module joystick_hsv_color_controller_core
	import jhsv_pkg::*;
#(
	parameter int COLOR_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [15:0]           stick_x,
	input  logic signed [15:0]           stick_y,
	input  logic [15:0]                  frame_time,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [COLOR_BITS-1:0]        inner_red,
	output logic [COLOR_BITS-1:0]        inner_green,
	output logic [COLOR_BITS-1:0]        inner_blue,
	output logic [COLOR_BITS-1:0]        outer_red,
	output logic [COLOR_BITS-1:0]        outer_green,
	output logic [COLOR_BITS-1:0]        outer_blue,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	cfg_t cfg_q;
	seq_ctrl_t ctrl;
	logic out_valid_q;
	logic out_free;
	logic [COLOR_BITS-1:0] res_ir, res_ig, res_ib, res_or, res_og, res_ob;
	logic [COLOR_BITS-1:0] ir_q, ig_q, ib_q, or_q, og_q, ob_q;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_speed <= 9'd180;
			cfg_q.value_speed <= 16'd39322;
			cfg_q.dead_zone <= 15'd4915;
			cfg_q.smoothing <= 16'd16384;
			cfg_q.value_floor <= 16'd3277;
			cfg_q.saturation <= 16'd58982;
			cfg_q.outer_scale <= 16'd26214;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HUE_SPEED:   cfg_q.hue_speed <= cfg_data[8:0];
				REG_VALUE_SPEED: cfg_q.value_speed <= cfg_data;
				REG_DEAD_ZONE:   cfg_q.dead_zone <= cfg_data[14:0];
				REG_SMOOTHING:   cfg_q.smoothing <= cfg_data;
				REG_VALUE_FLOOR: cfg_q.value_floor <= cfg_data;
				REG_SATURATION:  cfg_q.saturation <= cfg_data;
				REG_OUTER_SCALE: cfg_q.outer_scale <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	jhsv_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	jhsv_dpath #(
		.COLOR_BITS (COLOR_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg        (cfg_q),
		.stick_x    (stick_x),
		.stick_y    (stick_y),
		.frame_time (frame_time),
		.res_ir     (res_ir),
		.res_ig     (res_ig),
		.res_ib     (res_ib),
		.res_or     (res_or),
		.res_og     (res_og),
		.res_ob     (res_ob)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			ir_q <= res_ir;
			ig_q <= res_ig;
			ib_q <= res_ib;
			or_q <= res_or;
			og_q <= res_og;
			ob_q <= res_ob;
		end
	end

	assign in_ready = ctrl.in_ready;
	assign out_valid = out_valid_q;
	assign inner_red = ir_q;
	assign inner_green = ig_q;
	assign inner_blue = ib_q;
	assign outer_red = or_q;
	assign outer_green = og_q;
	assign outer_blue = ob_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice without finishing a beat");

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> (!out_valid || out_ready))
		else $error("result loaded over an untaken output beat");

	a_no_accept_while_finishing: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> !ctrl.load_in)
		else $error("input accepted in the same step that a result is loaded");

endmodule
